// File: rtl/bnf_pkg.sv
`timescale 1ns / 1ps

package bnf_pkg;

  // Register file of the configuration port.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END   = 1'b1;

  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_DATA_W-1:0] RESERVED_START_RST = 16'd512;
  localparam logic [CFG_DATA_W-1:0] RESERVED_END_RST   = 16'd768;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_OOM         = 2'd1,
    STAT_INVALID     = 2'd2,
    STAT_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [14:0] allocated_page;
    status_e     status;
  } out_item_t;

endpackage

// File: rtl/bnf_map_ram.sv
`timescale 1ns / 1ps

module bnf_map_ram #(
  parameter int unsigned WORDS = 512,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bnf_ctrl.sv
`timescale 1ns / 1ps

module bnf_ctrl #(
  parameter int unsigned PAGE_COUNT    = 32768,
  parameter int unsigned MAP_WORD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  bnf_pkg::in_item_t            req_i,
  output logic                         req_stall_o,
  input  logic [bnf_pkg::CFG_DATA_W-1:0] rsv_start_i,
  input  logic [bnf_pkg::CFG_DATA_W-1:0] rsv_end_i,
  output logic                         res_valid_o,
  output bnf_pkg::out_item_t           res_o,
  input  logic                         res_take_i
);

  // The word width is a power of two, so a page number splits into word and bit offset.
  localparam int unsigned MapWords = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned OW       = $clog2(MAP_WORD_BITS);
  localparam int unsigned AW       = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned PtrW     = AW + OW;
  localparam int unsigned CmpW     = ((PtrW > bnf_pkg::CFG_DATA_W) ? PtrW
                                      : bnf_pkg::CFG_DATA_W) + 1;
  localparam int unsigned GW       = (PtrW > 15) ? PtrW : 15;
  localparam int unsigned LastBits = PAGE_COUNT - (MapWords - 1) * MAP_WORD_BITS;
  localparam logic [MAP_WORD_BITS-1:0] LastMask =
      {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LastBits);
  localparam logic [AW-1:0]   LastWord  = AW'(MapWords - 1);
  localparam logic [CmpW-1:0] PageLimit = CmpW'(PAGE_COUNT);
  localparam logic [PtrW-1:0] PtrRst =
      (CmpW'(bnf_pkg::RESERVED_END_RST) >= PageLimit) ? '0
      : PtrW'(bnf_pkg::RESERVED_END_RST);

  bnf_pkg::state_e state_q, state_d;

  logic               lap_q;
  logic               init_q;
  logic [AW-1:0]      sweep_q;
  logic [PtrW-1:0]    ptr_q;
  logic [AW-1:0]      cur_q;
  logic [AW-1:0]      start_q;
  logic [OW-1:0]      off_q;
  bnf_pkg::out_item_t res_q;

  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic [MAP_WORD_BITS-1:0] mem_wdata;
  logic [MAP_WORD_BITS-1:0] mem_rdata;

  logic [MAP_WORD_BITS-1:0] word_valid;
  logic [MAP_WORD_BITS-1:0] ge_off;
  logic [MAP_WORD_BITS-1:0] region;
  logic [MAP_WORD_BITS-1:0] cand;
  logic [MAP_WORD_BITS-1:0] lsb;
  logic [MAP_WORD_BITS-1:0] free_bit;
  logic [MAP_WORD_BITS-1:0] init_mask;
  logic [OW-1:0]            idx;
  logic                     found;
  logic                     free_used;
  logic [AW-1:0]            next_word;
  logic [PtrW-1:0]          grant;
  logic [GW-1:0]            grant_ext;
  logic [CmpW-1:0]          grant_inc;
  logic [PtrW-1:0]          ptr_next;
  logic [CmpW-1:0]          pn_ext;
  logic                     pn_bad;
  logic [CmpW-1:0]          rs_ext;
  logic [CmpW-1:0]          re_ext;
  logic [PtrW-1:0]          re_wrap;
  logic                     sweep_last;
  logic                     req_xfer;

  bnf_map_ram #(
    .WORDS (MapWords),
    .WIDTH (MAP_WORD_BITS),
    .AW    (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Bits of word w whose page number is at or above x.
  function automatic logic [MAP_WORD_BITS-1:0] ge_mask(input logic [CmpW-1:0] x,
                                                       input logic [AW-1:0]   w);
    logic [CmpW-1:0] xw;
    logic [CmpW-1:0] wx;
    xw = x >> OW;
    wx = CmpW'(w);
    if (wx > xw) begin
      ge_mask = '1;
    end else if (wx == xw) begin
      ge_mask = {MAP_WORD_BITS{1'b1}} << x[OW-1:0];
    end else begin
      ge_mask = '0;
    end
  endfunction

  assign req_xfer   = req_valid_i && (state_q == bnf_pkg::S_IDLE);
  assign sweep_last = (sweep_q == LastWord);

  always_comb begin
    pn_ext  = CmpW'(req_i.page_number);
    pn_bad  = (pn_ext >= PageLimit);
    rs_ext  = CmpW'(rsv_start_i);
    re_ext  = CmpW'(rsv_end_i);
    re_wrap = (re_ext >= PageLimit) ? '0 : re_ext[PtrW-1:0];

    init_mask = ge_mask(rs_ext, sweep_q) & ~ge_mask(re_ext, sweep_q);

    // Bits past the last page behave as used so the scan never grants them.
    word_valid = (cur_q == LastWord) ? LastMask : '1;
    ge_off     = {MAP_WORD_BITS{1'b1}} << off_q;
    // First visit of the start word covers the pointer onward, the final one the rest.
    if (lap_q) begin
      region = ~ge_off;
    end else if (cur_q == start_q) begin
      region = ge_off;
    end else begin
      region = '1;
    end

    cand  = ~mem_rdata & word_valid & region;
    found = |cand;
    lsb   = cand & (~cand + 1'b1);
    idx   = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      if (lsb[b]) begin
        idx = idx | OW'(b);
      end
    end

    next_word = (cur_q == LastWord) ? '0 : cur_q + 1'b1;
    grant     = {cur_q, idx};
    grant_ext = GW'(grant);
    grant_inc = CmpW'(grant) + 1'b1;
    ptr_next  = (grant_inc >= PageLimit) ? '0 : grant_inc[PtrW-1:0];

    free_bit  = {{(MAP_WORD_BITS-1){1'b0}}, 1'b1} << off_q;
    free_used = |(mem_rdata & free_bit);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bnf_pkg::S_CLEAR: begin
        if (sweep_last) begin
          state_d = init_q ? bnf_pkg::S_DONE : bnf_pkg::S_IDLE;
        end
      end
      bnf_pkg::S_IDLE: begin
        if (req_valid_i) begin
          case (req_i.operation)
            bnf_pkg::OP_ALLOC: state_d = bnf_pkg::S_ALLOC;
            bnf_pkg::OP_FREE:  state_d = pn_bad ? bnf_pkg::S_DONE : bnf_pkg::S_FREE_CHK;
            bnf_pkg::OP_INIT:  state_d = bnf_pkg::S_CLEAR;
            default:           state_d = bnf_pkg::S_DONE;
          endcase
        end
      end
      bnf_pkg::S_ALLOC: begin
        if (found || lap_q) begin
          state_d = bnf_pkg::S_DONE;
        end
      end
      bnf_pkg::S_FREE_CHK: state_d = bnf_pkg::S_DONE;
      bnf_pkg::S_DONE: begin
        if (res_take_i) begin
          state_d = bnf_pkg::S_IDLE;
        end
      end
      default: state_d = bnf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_addr    = cur_q;
    mem_wdata   = mem_rdata;
    req_stall_o = (state_q != bnf_pkg::S_IDLE);
    res_valid_o = (state_q == bnf_pkg::S_DONE);
    case (state_q)
      bnf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = sweep_q;
        mem_wdata = init_q ? init_mask : '0;
      end
      bnf_pkg::S_IDLE: begin
        if (req_i.operation == bnf_pkg::OP_ALLOC) begin
          mem_addr = ptr_q[PtrW-1:OW];
        end else begin
          mem_addr = pn_ext[PtrW-1:OW];
        end
      end
      bnf_pkg::S_ALLOC: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata | lsb;
        end else begin
          mem_addr = next_word;
        end
      end
      bnf_pkg::S_FREE_CHK: begin
        mem_we    = free_used;
        mem_wdata = mem_rdata & ~free_bit;
      end
      bnf_pkg::S_DONE: begin
        mem_addr = cur_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // A reset starts a sweep that clears the whole bitmap before the first transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bnf_pkg::S_CLEAR;
      lap_q   <= 1'b0;
      init_q  <= 1'b0;
      sweep_q <= '0;
      ptr_q   <= PtrRst;
    end else begin
      state_q <= state_d;
      case (state_q)
        bnf_pkg::S_CLEAR: begin
          sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
          if (sweep_last && init_q) begin
            ptr_q  <= re_wrap;
            init_q <= 1'b0;
          end
        end
        bnf_pkg::S_IDLE: begin
          if (req_xfer) begin
            lap_q <= 1'b0;
            if (req_i.operation == bnf_pkg::OP_INIT) begin
              init_q  <= 1'b1;
              sweep_q <= '0;
            end
          end
        end
        bnf_pkg::S_ALLOC: begin
          if (found) begin
            ptr_q <= ptr_next;
          end else if (!lap_q && next_word == start_q) begin
            lap_q <= 1'b1;
          end
        end
        default: begin
          lap_q <= lap_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bnf_pkg::S_CLEAR: begin
        res_q <= '{allocated_page: '0, status: bnf_pkg::STAT_OK};
      end
      bnf_pkg::S_IDLE: begin
        if (req_xfer) begin
          if (req_i.operation == bnf_pkg::OP_ALLOC) begin
            cur_q   <= ptr_q[PtrW-1:OW];
            start_q <= ptr_q[PtrW-1:OW];
            off_q   <= ptr_q[OW-1:0];
          end else begin
            cur_q <= pn_ext[PtrW-1:OW];
            off_q <= pn_ext[OW-1:0];
          end
          res_q <= '{allocated_page: '0,
                     status: (req_i.operation == bnf_pkg::OP_FREE && pn_bad)
                             ? bnf_pkg::STAT_INVALID : bnf_pkg::STAT_OK};
        end
      end
      bnf_pkg::S_ALLOC: begin
        if (found) begin
          res_q <= '{allocated_page: grant_ext[14:0], status: bnf_pkg::STAT_OK};
        end else if (lap_q) begin
          res_q <= '{allocated_page: '0, status: bnf_pkg::STAT_OOM};
        end else begin
          cur_q <= next_word;
        end
      end
      bnf_pkg::S_FREE_CHK: begin
        res_q <= '{allocated_page: '0,
                   status: free_used ? bnf_pkg::STAT_OK : bnf_pkg::STAT_DOUBLE_FREE};
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == bnf_pkg::S_IDLE || state_q == bnf_pkg::S_DONE) |-> !mem_we)
    else $error("bitmap written outside a sweep or read-modify-write");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      CmpW'(ptr_q) < PageLimit)
    else $error("scan pointer beyond the last page");

  a_lap_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == bnf_pkg::S_ALLOC && lap_q) |-> (cur_q == start_q))
    else $error("final scan pass not on the start word");

  // The edge that releases reset still holds the sweep counter, so it starts no check.
  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rst_ni && state_q == bnf_pkg::S_CLEAR && !sweep_last)
      |=> (sweep_q == $past(sweep_q) + 1'b1))
    else $error("clear sweep skipped a word");
`endif

endmodule

// File: rtl/bitmap_next_fit_page_allocator.sv
`timescale 1ns / 1ps

// Allocate scans the bitmap one word per cycle, at most the word count plus one words;
// free checks the page's bit and clears it if set; init sweeps every word once.
// Throughput: one request at a time, set by the single port of the bitmap memory.
// Reset: after reset the bitmap is cleared by a sweep over all PAGE_COUNT / MAP_WORD_BITS words
// (512 at the defaults), during which no request is taken; configuration writes still land.
module bitmap_next_fit_page_allocator #(
  parameter int unsigned PAGE_COUNT    = 32768,
  parameter int unsigned MAP_WORD_BITS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bnf_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bnf_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [bnf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bnf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [bnf_pkg::CFG_DATA_W-1:0] rsv_start_q;
  logic [bnf_pkg::CFG_DATA_W-1:0] rsv_end_q;
  logic                           out_valid_q;
  bnf_pkg::out_item_t             out_data_q;
  logic                           res_valid;
  logic                           res_take;
  bnf_pkg::out_item_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_start_q <= bnf_pkg::RESERVED_START_RST;
      rsv_end_q   <= bnf_pkg::RESERVED_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bnf_pkg::CFG_RESERVED_START: rsv_start_q <= cfg_wdata_i;
        bnf_pkg::CFG_RESERVED_END:   rsv_end_q   <= cfg_wdata_i;
        default:                     rsv_start_q <= rsv_start_q;
      endcase
    end
  end

  bnf_ctrl #(
    .PAGE_COUNT    (PAGE_COUNT),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .req_stall_o (in_stall_o),
    .rsv_start_i (rsv_start_q),
    .rsv_end_i   (rsv_end_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // The output register takes a new result when it is empty or its current one is being transferred.
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PAGE_COUNT = 32768;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 82;
  localparam int unsigned DIRECTED_ROWS = 20;

  typedef struct {
    logic [1:0]       op_code;
    logic [15:0]      page;
    bit               typed;
    logic [14:0]      want_page;
    bnf_pkg::status_e want_status;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  bnf_pkg::in_item_t in_data = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [bnf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bnf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  bnf_pkg::out_item_t out_data;

  // Allocator state as the testbench sees it.
  bit page_used [PAGE_COUNT];
  int unsigned scan_ptr;
  logic [15:0] rsv_start;
  logic [15:0] rsv_end;
  int unsigned granted_pages [$];

  bnf_pkg::out_item_t expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned status_seen [4];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  bitmap_next_fit_page_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Timeout: %0d results still outstanding", expected_results.size());
    $display("** bitmap_next_fit_page_allocator: FAILED **");
    $finish;
  end

  function automatic bnf_pkg::out_item_t predict_request(input logic [1:0] op_code,
                                                         input logic [15:0] page);
    bnf_pkg::out_item_t result;
    int unsigned p;
    int unsigned stop;
    int unsigned k;
    bit found;
    result = '{allocated_page: '0, status: bnf_pkg::STAT_OK};
    case (op_code)
      bnf_pkg::OP_ALLOC: begin
        p = scan_ptr;
        found = 1'b0;
        for (k = 0; k < PAGE_COUNT; k++) begin
          if (!page_used[p]) begin
            found = 1'b1;
            break;
          end
          p = (p + 1 == PAGE_COUNT) ? 0 : p + 1;
        end
        if (found) begin
          page_used[p] = 1'b1;
          result.allocated_page = p[14:0];
          scan_ptr = (p + 1 == PAGE_COUNT) ? 0 : p + 1;
          granted_pages.push_back(p);
        end else begin
          result.status = bnf_pkg::STAT_OOM;
        end
      end
      bnf_pkg::OP_FREE: begin
        if (page >= PAGE_COUNT) begin
          result.status = bnf_pkg::STAT_INVALID;
        end else if (!page_used[page]) begin
          result.status = bnf_pkg::STAT_DOUBLE_FREE;
        end else begin
          page_used[page] = 1'b0;
        end
      end
      bnf_pkg::OP_INIT: begin
        foreach (page_used[i]) page_used[i] = 1'b0;
        stop = (rsv_end < PAGE_COUNT) ? rsv_end : PAGE_COUNT;
        for (p = rsv_start; p < stop; p++) page_used[p] = 1'b1;
        scan_ptr = (rsv_end >= PAGE_COUNT) ? 0 : rsv_end;
        granted_pages.delete();
      end
      default: begin
      end
    endcase
    return result;
  endfunction

  task automatic issue_request(input logic [1:0] op_code, input logic [15:0] page,
                               input bit typed, input bnf_pkg::out_item_t typed_result);
    bnf_pkg::out_item_t predicted;
    in_valid <= 1'b1;
    in_data <= {op_code, page};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_request(op_code, page);
    expected_results.push_back(typed ? typed_result : predicted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic random_request();
    int unsigned pick;
    int unsigned slot;
    pick = $urandom_range(99);
    if (pick < 45 || (pick < 80 && granted_pages.size() == 0)) begin
      issue_request(bnf_pkg::OP_ALLOC, 16'($urandom_range(65535)), 1'b0, '0);
    end else if (pick < 80) begin
      // Hand back a page that an earlier allocation granted.
      slot = $urandom_range(granted_pages.size() - 1);
      issue_request(bnf_pkg::OP_FREE, 16'(granted_pages[slot]), 1'b0, '0);
      granted_pages.delete(slot);
    end else if (pick < 88) begin
      issue_request(bnf_pkg::OP_FREE, 16'($urandom_range(PAGE_COUNT - 1)), 1'b0, '0);
    end else if (pick < 93) begin
      issue_request(bnf_pkg::OP_FREE, 16'($urandom_range(65535, PAGE_COUNT)), 1'b0, '0);
    end else if (pick < 97) begin
      issue_request(OP_UNUSED, 16'($urandom_range(65535)), 1'b0, '0);
    end else begin
      issue_request(bnf_pkg::OP_INIT, 16'($urandom_range(65535)), 1'b0, '0);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [15:0] first, input logic [15:0] past);
    cfg_we <= 1'b1;
    cfg_index <= bnf_pkg::CFG_RESERVED_START;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_index <= bnf_pkg::CFG_RESERVED_END;
    cfg_wdata <= past;
    @(posedge clk);
    cfg_we <= 1'b0;
    rsv_start = first;
    rsv_end = past;
  endtask

  task automatic set_idling(input int unsigned phase);
    if (phase < 3) begin
      send_idle_pct = 29;
      recv_idle_pct = 70;
    end else if (phase < 6) begin
      send_idle_pct = 70;
      recv_idle_pct = 29;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    bnf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      status_seen[out_data.status]++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected: page %0d status %0d",
                 $time, out_data.allocated_page, out_data.status);
      end else begin
        want = expected_results.pop_front();
        if (out_data.allocated_page !== want.allocated_page) begin
          mismatch_count++;
          $display("%0t: allocated_page mismatch: expected %0d, actual %0d",
                   $time, want.allocated_page, out_data.allocated_page);
        end
        if (out_data.status !== want.status) begin
          mismatch_count++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
      end
    end
  end

  initial begin
    directed_row_t dir_rows [DIRECTED_ROWS];
    logic [15:0] phase_start [RANDOM_PHASES];
    logic [15:0] phase_end [RANDOM_PHASES];
    int unsigned phase;
    int unsigned n;

    // After reset the map is clear and the pointer sits at the end of the
    // default reserved range; the range itself is only marked by an init.
    dir_rows = '{
      '{bnf_pkg::OP_ALLOC, 16'h0000,  1'b1, 15'd768, bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_ALLOC, 16'hFFFF,  1'b1, 15'd769, bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd768,   1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd768,   1'b1, 15'd0,   bnf_pkg::STAT_DOUBLE_FREE},
      '{bnf_pkg::OP_FREE,  16'h8000,  1'b1, 15'd0,   bnf_pkg::STAT_INVALID},
      '{bnf_pkg::OP_FREE,  16'hFFFF,  1'b1, 15'd0,   bnf_pkg::STAT_INVALID},
      '{bnf_pkg::OP_FREE,  16'd0,     1'b1, 15'd0,   bnf_pkg::STAT_DOUBLE_FREE},
      '{bnf_pkg::OP_FREE,  16'd32767, 1'b1, 15'd0,   bnf_pkg::STAT_DOUBLE_FREE},
      '{OP_UNUSED,         16'hFFFF,  1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{OP_UNUSED,         16'h0000,  1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_ALLOC, 16'h0000,  1'b1, 15'd770, bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_INIT,  16'h5A5A,  1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_ALLOC, 16'h0000,  1'b1, 15'd768, bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd512,   1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd767,   1'b1, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd511,   1'b1, 15'd0,   bnf_pkg::STAT_DOUBLE_FREE},
      '{bnf_pkg::OP_FREE,  16'd769,   1'b1, 15'd0,   bnf_pkg::STAT_DOUBLE_FREE},
      '{bnf_pkg::OP_ALLOC, 16'h0000,  1'b0, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_ALLOC, 16'h0000,  1'b0, 15'd0,   bnf_pkg::STAT_OK},
      '{bnf_pkg::OP_FREE,  16'd768,   1'b0, 15'd0,   bnf_pkg::STAT_OK}
    };
    // Whole map reserved, eight pages left at the top, empty ranges, a range
    // running past the map, a random range, and the defaults again.
    phase_start = '{16'd0, 16'd0, 16'd100, 16'hFFFF, 16'd32700, 16'd0, 16'd0, 16'd512};
    phase_end   = '{16'd32768, 16'd32760, 16'd50, 16'hFFFF, 16'd40000, 16'd0, 16'd0, 16'd768};
    phase_start[6] = 16'($urandom_range(PAGE_COUNT - 1));
    phase_end[6] = phase_start[6] + 16'($urandom_range(2000));

    foreach (page_used[i]) page_used[i] = 1'b0;
    scan_ptr = bnf_pkg::RESERVED_END_RST;
    rsv_start = bnf_pkg::RESERVED_START_RST;
    rsv_end = bnf_pkg::RESERVED_END_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The register file accepts writes while the map is still being swept.
    write_reserved(bnf_pkg::RESERVED_START_RST, bnf_pkg::RESERVED_END_RST);

    set_idling(0);
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      issue_request(dir_rows[n].op_code, dir_rows[n].page, dir_rows[n].typed,
                    '{allocated_page: dir_rows[n].want_page,
                      status: dir_rows[n].want_status});
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      set_idling(phase);
      write_reserved(phase_start[phase], phase_end[phase]);
      issue_request(bnf_pkg::OP_INIT, 16'($urandom_range(65535)), 1'b0, '0);
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_request();
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Checked %0d results: %0d ok, %0d out of memory, %0d invalid, %0d double free.",
             result_count, status_seen[bnf_pkg::STAT_OK], status_seen[bnf_pkg::STAT_OOM],
             status_seen[bnf_pkg::STAT_INVALID], status_seen[bnf_pkg::STAT_DOUBLE_FREE]);
    $display("Covered %0d reserved-range settings under three sender/receiver idling mixes.",
             RANDOM_PHASES + 1);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** bitmap_next_fit_page_allocator: PASSED **");
    end else begin
      $display("** bitmap_next_fit_page_allocator: FAILED **");
    end
    $finish;
  end

endmodule
